>>> rtl/core/rmth_pkg.sv
// Shared types and constants for the running median block.
package rmth_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int COUNT_OUT_W = 11;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_REPLACE
   } chain_op_type;

   typedef struct packed {
      chain_op_type               op;
      logic signed [SAMPLE_W-1:0] value;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FORM,
      ST_SEND
   } state_type;

endpackage

>>> rtl/core/rmth_cell.sv
// One sorted cell of a priority chain: holds one sample and takes its next value from neighbors.
module rmth_cell import rmth_pkg::*; #(
   parameter bit IS_MAX = 1'b1
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [SAMPLE_W-1:0] value,
   input  logic signed [SAMPLE_W-1:0] d_self,
   input  logic                       d_self_valid,
   input  logic signed [SAMPLE_W-1:0] d_prev,
   input  logic                       vb_prev,
   output logic                       vb,
   output logic signed [SAMPLE_W-1:0] q
);

   logic signed [SAMPLE_W-1:0] q_ff, q_in;
   logic                       above;

   // The new value sorts ahead of this cell's candidate when it strictly outranks it.
   assign above = IS_MAX ? (value > d_self) : (value < d_self);
   assign vb    = !d_self_valid || above;

   always_comb begin
      if (!vb) begin
         q_in = d_self;
      end else if (!vb_prev) begin
         q_in = value;
      end else begin
         q_in = d_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

>>> rtl/core/rmth_chain.sv
// A row of sorted cells forming one half of the store, best element in cell zero.
module rmth_chain import rmth_pkg::*; #(
   parameter int  DEPTH   = 512,
   parameter int  COUNT_W = 11,
   parameter bit  IS_MAX  = 1'b1
) (
   input  logic                       clock,
   input  chain_ctrl_type             ctrl,
   input  logic [COUNT_W-1:0]         count,
   output logic signed [SAMPLE_W-1:0] top
);

   logic signed [SAMPLE_W-1:0] q   [DEPTH];
   logic signed [SAMPLE_W-1:0] d   [DEPTH];
   logic                       dv  [DEPTH];
   logic                       vb  [DEPTH];
   logic [COUNT_W-1:0]         n_eff;
   logic                       en;

   // A replace drops the top first, so every cell but the last looks one place to its right.
   assign n_eff = (ctrl.op == OP_REPLACE) ? count - COUNT_W'(1) : count;
   assign en    = (ctrl.op != OP_NONE);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i + 1 < DEPTH) begin : g_mid
         assign d[i] = (ctrl.op == OP_REPLACE) ? q[i+1] : q[i];
      end else begin : g_end
         assign d[i] = q[i];
      end
      assign dv[i] = (COUNT_W'(i) < n_eff);

      if (i == 0) begin : g_first
         rmth_cell #(.IS_MAX(IS_MAX)) u_cell (
            .clock        (clock),
            .en           (en),
            .value        (ctrl.value),
            .d_self       (d[i]),
            .d_self_valid (dv[i]),
            .d_prev       ('0),
            .vb_prev      (1'b0),
            .vb           (vb[i]),
            .q            (q[i])
         );
      end else begin : g_rest
         rmth_cell #(.IS_MAX(IS_MAX)) u_cell (
            .clock        (clock),
            .en           (en),
            .value        (ctrl.value),
            .d_self       (d[i]),
            .d_self_valid (dv[i]),
            .d_prev       (d[i-1]),
            .vb_prev      (vb[i-1]),
            .vb           (vb[i]),
            .q            (q[i])
         );
      end
   end

   assign top = q[0];

endmodule

>>> rtl/core/running_median_two_heaps_top.sv
// Top level of the running median block: control, counts and result register.
//
// Usage: each request on req_ carries one signed 32-bit sample. The block keeps
// every sample in two sorted rows of cells, the lower half with its largest
// value in front and the upper half with its smallest value in front. A sample
// that belongs on the other side displaces that row's front entry, which moves
// across; all cells of a row that changes update in the same clock edge.
// One result leaves on rsp_ per request: twice the median of all held samples,
// the sample count, and a dropped flag on tuser when the store already held
// CAPACITY samples (the sample is then ignored).
// One request is in flight at a time: the block takes no new request until the
// result has been handed off. The cell rows update as the request is taken,
// the ST_FORM state forms the result into its register, and the ST_SEND state
// presents it on rsp_ until the receiver takes it.
// Reset clears both counts, so the store is empty; cell contents are not reset.
// While the receiver holds rsp_tready low the result waits in its register and
// req_tready stays low.
module running_median_two_heaps_top import rmth_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [32:0] median_doubled, [43:33] sample_count, rest zero
   output logic        rsp_tuser    // [0] dropped
);

   localparam int LOWER_DEPTH = CAPACITY / 2;
   localparam int UPPER_DEPTH = (CAPACITY + 1) / 2;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] lower_cnt_ff, lower_cnt_in;
   logic [COUNT_W-1:0] upper_cnt_ff, upper_cnt_in;
   logic               dropped_ff, dropped_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   chain_ctrl_type lower_ctrl, upper_ctrl;
   logic signed [SAMPLE_W-1:0] lower_top, upper_top, sample;
   logic [COUNT_W-1:0] total;
   logic               accept;

   assign sample = req_tdata;
   assign total  = lower_cnt_ff + upper_cnt_ff;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      lower_ctrl   = '{op: OP_NONE, value: sample};
      upper_ctrl   = '{op: OP_NONE, value: sample};
      lower_cnt_in = lower_cnt_ff;
      upper_cnt_in = upper_cnt_ff;
      dropped_in   = dropped_ff;
      if (accept) begin
         dropped_in = (total >= COUNT_W'(CAPACITY));
         if (total >= COUNT_W'(CAPACITY)) begin
            dropped_in = 1'b1;
         end else if (!total[0]) begin
            upper_cnt_in = upper_cnt_ff + COUNT_W'(1);
            if (lower_cnt_ff != '0 && sample < lower_top) begin
               lower_ctrl = '{op: OP_REPLACE, value: sample};
               upper_ctrl = '{op: OP_PUSH, value: lower_top};
            end else begin
               upper_ctrl = '{op: OP_PUSH, value: sample};
            end
         end else begin
            lower_cnt_in = lower_cnt_ff + COUNT_W'(1);
            if (upper_cnt_ff != '0 && sample > upper_top) begin
               upper_ctrl = '{op: OP_REPLACE, value: sample};
               lower_ctrl = '{op: OP_PUSH, value: upper_top};
            end else begin
               lower_ctrl = '{op: OP_PUSH, value: sample};
            end
         end
      end
   end

   rmth_chain #(.DEPTH(LOWER_DEPTH), .COUNT_W(COUNT_W), .IS_MAX(1'b1)) u_lower (
      .clock (clock),
      .ctrl  (lower_ctrl),
      .count (lower_cnt_ff),
      .top   (lower_top)
   );

   rmth_chain #(.DEPTH(UPPER_DEPTH), .COUNT_W(COUNT_W), .IS_MAX(1'b0)) u_upper (
      .clock (clock),
      .ctrl  (upper_ctrl),
      .count (upper_cnt_ff),
      .top   (upper_top)
   );

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      median_in  = median_ff;
      total_in   = total_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            total_in = total;
            if (total[0]) begin
               median_in = {upper_top, 1'b0};
            end else begin
               median_in = MEDIAN_W'(upper_top) + MEDIAN_W'(lower_top);
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         lower_cnt_ff <= lower_cnt_in;
         upper_cnt_ff <= upper_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      median_ff  <= median_in;
      total_ff   <= total_in;
   end

   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = {4'b0, COUNT_OUT_W'(total_ff), median_ff};
   assign rsp_tuser  = dropped_ff;

`ifndef SYNTHESIS
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (upper_cnt_ff == lower_cnt_ff) || (upper_cnt_ff == lower_cnt_ff + COUNT_W'(1)))
      else $error("halves out of balance");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result waits");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FORM))
      else $error("accepted request did not start a result");
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      total <= COUNT_W'(CAPACITY))
      else $error("store holds more than its capacity");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the running median block with its own two-heap model.
module tb;
   import rmth_pkg::*;

   localparam int CAP = CAPACITY_DEFAULT;

   typedef struct packed {
      logic signed [MEDIAN_W-1:0] median_doubled;
      logic [COUNT_OUT_W-1:0]     sample_count;
      logic                       dropped;
   } median_result_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       has_expected;
      median_result_type          expected;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   running_median_two_heaps_top #(.CAPACITY(CAP)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   initial begin
      #200000000;
      $display("TEST FAILED");
      $finish;
   end

   // Model state: the max-heap of the lower half and the min-heap of the upper half.
   logic signed [31:0] low_heap [CAP/2];
   logic signed [31:0] high_heap [(CAP+1)/2];
   int unsigned        low_n, high_n;
   median_result_type  pending_medians [$];
   int                 error_count = 0;
   int                 send_idle_pct = 0, recv_idle_pct = 0;
   bit                 hold_off = 1'b0;

   function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                      bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_insert(bit is_max, logic signed [31:0] v);
      int unsigned pos, parent;
      logic signed [31:0] t;
      pos = is_max ? low_n : high_n;
      if (is_max) low_heap[pos] = v; else high_heap[pos] = v;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (is_max) begin
            if (!ranks_above(low_heap[pos], low_heap[parent], 1)) break;
            t = low_heap[pos]; low_heap[pos] = low_heap[parent]; low_heap[parent] = t;
         end else begin
            if (!ranks_above(high_heap[pos], high_heap[parent], 0)) break;
            t = high_heap[pos]; high_heap[pos] = high_heap[parent]; high_heap[parent] = t;
         end
         pos = parent;
      end
      if (is_max) low_n++; else high_n++;
   endtask

   // Puts v on top, sifts it down and hands back the displaced top.
   task automatic heap_swap_top(bit is_max, logic signed [31:0] v,
                                output logic signed [31:0] old_top);
      int unsigned pos, l, r, best, n;
      logic signed [31:0] t;
      n = is_max ? low_n : high_n;
      pos = 0;
      if (is_max) begin old_top = low_heap[0]; low_heap[0] = v; end
      else begin old_top = high_heap[0]; high_heap[0] = v; end
      forever begin
         l = 2 * pos + 1; r = l + 1; best = pos;
         if (is_max) begin
            if (l < n && low_heap[l] > low_heap[best]) best = l;
            if (r < n && low_heap[r] > low_heap[best]) best = r;
            if (best == pos) break;
            t = low_heap[pos]; low_heap[pos] = low_heap[best]; low_heap[best] = t;
         end else begin
            if (l < n && high_heap[l] < high_heap[best]) best = l;
            if (r < n && high_heap[r] < high_heap[best]) best = r;
            if (best == pos) break;
            t = high_heap[pos]; high_heap[pos] = high_heap[best]; high_heap[best] = t;
         end
         pos = best;
      end
   endtask

   task automatic predict_median(logic signed [31:0] sample, output median_result_type res);
      logic signed [31:0] v;
      int unsigned total;
      v = sample;
      total = low_n + high_n;
      res.dropped = 1'b0;
      if (total >= CAP) res.dropped = 1'b1;
      else if (total % 2 == 0) begin
         if (low_n > 0 && v < low_heap[0]) heap_swap_top(1, sample, v);
         heap_insert(0, v);
      end else begin
         if (high_n > 0 && v > high_heap[0]) heap_swap_top(0, sample, v);
         heap_insert(1, v);
      end
      total = low_n + high_n;
      if (total % 2 == 1) res.median_doubled = 33'(high_heap[0]) <<< 1;
      else res.median_doubled = 33'(high_heap[0]) + 33'(low_heap[0]);
      res.sample_count = total[COUNT_OUT_W-1:0];
   endtask

   // Valid stays high after a request until the next falling edge decides what comes next.
   task automatic send_sample(logic signed [31:0] sample, bit has_exp,
                              median_result_type exp_res);
      median_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_median(sample, res);
      // Rows with a typed result are checked against that value directly.
      pending_medians.insert(pending_medians.size(), has_exp ? exp_res : res);
      @(negedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      median_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.median_doubled = rsp_tdata[32:0];
         got.sample_count   = rsp_tdata[43:33];
         got.dropped        = rsp_tuser;
         if (pending_medians.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
         end else begin
            want = pending_medians.pop_front();
            if (got.median_doubled !== want.median_doubled) begin
               $error("median_doubled expected %0d actual %0d",
                      want.median_doubled, got.median_doubled);
               error_count++;
            end
            if (got.sample_count !== want.sample_count) begin
               $error("sample_count expected %0d actual %0d",
                      want.sample_count, got.sample_count);
               error_count++;
            end
            if (got.dropped !== want.dropped) begin
               $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
               error_count++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(40)) - 20;
         2: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                     : 32'h80000000 + $urandom_range(3);
         default: return $urandom_range(1000);
      endcase
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_medians.size() != 0);
   endtask

   stim_row_type directed_rows [] = '{
      '{32'sh7FFFFFFF, 1'b1, '{33'sh0FFFFFFFE, 11'd1, 1'b0}},
      '{32'sh80000000, 1'b1, '{33'sh1FFFFFFFF, 11'd2, 1'b0}},
      '{32'sh80000000, 1'b1, '{33'sh100000000, 11'd3, 1'b0}},
      '{32'sh7FFFFFFF, 1'b0, '{'0, '0, '0}},
      '{32'sh00000000, 1'b0, '{'0, '0, '0}},
      '{-32'sd1,       1'b0, '{'0, '0, '0}},
      '{32'sd1,        1'b0, '{'0, '0, '0}},
      '{32'sh55555555, 1'b0, '{'0, '0, '0}},
      '{32'shAAAAAAAA, 1'b0, '{'0, '0, '0}},
      '{32'sd5,        1'b0, '{'0, '0, '0}},
      '{32'sd5,        1'b0, '{'0, '0, '0}},
      '{-32'sd7,       1'b0, '{'0, '0, '0}}
   };

   initial begin
      median_result_type none;
      none = '0;
      low_n = 0; high_n = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].has_expected,
                     directed_rows[i].expected);

      // Random phases with the sender idling less first, then the receiver, then none.
      send_idle_pct = 20; recv_idle_pct = 76;
      repeat (250) send_sample(rand_sample(), 1'b0, none);
      send_idle_pct = 76; recv_idle_pct = 20;
      repeat (250) send_sample(rand_sample(), 1'b0, none);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;

      // Long receiver hold-off while requests keep coming; the block must stall.
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (20) send_sample(rand_sample(), 1'b0, none);
      join

      // Fill the store to capacity so that the drop case is reached.
      while (low_n + high_n < CAP) send_sample(rand_sample(), 1'b0, none);
      repeat (12) send_sample(rand_sample(), 1'b0, none);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
